// File: src/ffd_pkg.sv
package ffd_pkg;

    localparam int FRAME_BYTES = 133;
    localparam int CHECK_POS   = 130;
    localparam int TAIL_POS    = 131;
    localparam int ADDR_W      = 8;
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam logic OP_RX   = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_FIRST  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_SECOND = 2'd3;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_TAIL     = 2'd1,
        ERR_CHECKSUM = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_DONE  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        addr_t     addr;
        byte_t     data;
        err_t      err;
    } cmd_t;

    typedef struct packed {
        byte_t sync_first;
        byte_t sync_second;
        byte_t tail_first;
        byte_t tail_second;
    } cfg_t;

endpackage

// File: src/ffd_ram.sv
module ffd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 133
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/ffd_fifo.sv
module ffd_fifo #(
    parameter int DEPTH = ffd_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ffd_pkg::cmd_t wdata,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output ffd_pkg::cmd_t rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ffd_pkg::cmd_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: src/ffd_front.sv
module ffd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          op,
    input  logic [7:0]    rx_byte,
    input  logic [7:0]    read_index,
    input  ffd_pkg::cfg_t cfg,
    input  logic          queue_full,
    output logic          cmd_push,
    output ffd_pkg::cmd_t cmd
);

    ffd_pkg::addr_t fill_reg;
    ffd_pkg::addr_t fill_next;
    ffd_pkg::byte_t xor_reg;
    ffd_pkg::byte_t xor_next;
    ffd_pkg::byte_t chk_reg;
    ffd_pkg::byte_t chk_next;
    ffd_pkg::byte_t tail_reg;
    ffd_pkg::byte_t tail_next;
    logic           accept;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        fill_next = fill_reg;
        xor_next  = xor_reg;
        chk_next  = chk_reg;
        tail_next = tail_reg;
        cmd_push  = 1'b0;
        cmd.kind  = ffd_pkg::CMD_WRITE;
        cmd.addr  = fill_reg;
        cmd.data  = rx_byte;
        cmd.err   = ffd_pkg::ERR_NONE;
        if (accept)
        begin
            if (op == ffd_pkg::OP_READ)
            begin
                cmd_push = 1'b1;
                cmd.kind = ffd_pkg::CMD_READ;
                cmd.addr = read_index;
            end
            else if (fill_reg == '0)
            begin
                if (rx_byte == cfg.sync_first)
                begin
                    cmd_push  = 1'b1;
                    cmd.addr  = '0;
                    cmd.data  = cfg.sync_first;
                    fill_next = ffd_pkg::addr_t'(1);
                    xor_next  = cfg.sync_first;
                end
            end
            else if (fill_reg == ffd_pkg::addr_t'(1))
            begin
                if (rx_byte == cfg.sync_second)
                begin
                    cmd_push  = 1'b1;
                    fill_next = ffd_pkg::addr_t'(2);
                    xor_next  = xor_reg ^ rx_byte;
                end
                else if (rx_byte == cfg.sync_first)
                begin
                    cmd_push  = 1'b1;
                    cmd.addr  = '0;
                    cmd.data  = cfg.sync_first;
                    fill_next = ffd_pkg::addr_t'(1);
                    xor_next  = cfg.sync_first;
                end
                else
                begin
                    fill_next = '0;
                end
            end
            else
            begin
                cmd_push  = 1'b1;
                fill_next = fill_reg + ffd_pkg::addr_t'(1);
                if (fill_reg < ffd_pkg::addr_t'(ffd_pkg::CHECK_POS))
                begin
                    xor_next = xor_reg ^ rx_byte;
                end
                if (fill_reg == ffd_pkg::addr_t'(ffd_pkg::CHECK_POS))
                begin
                    chk_next = rx_byte;
                end
                if (fill_reg == ffd_pkg::addr_t'(ffd_pkg::TAIL_POS))
                begin
                    tail_next = rx_byte;
                end
                if (fill_reg == ffd_pkg::addr_t'(ffd_pkg::FRAME_BYTES - 1))
                begin
                    cmd.kind  = ffd_pkg::CMD_DONE;
                    fill_next = '0;
                    xor_next  = '0;
                    if (tail_reg != cfg.tail_first || rx_byte != cfg.tail_second)
                    begin
                        cmd.err = ffd_pkg::ERR_TAIL;
                    end
                    else if (xor_reg != chk_reg)
                    begin
                        cmd.err = ffd_pkg::ERR_CHECKSUM;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            xor_reg  <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            xor_reg  <= xor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_reg  <= chk_next;
        tail_reg <= tail_next;
    end

endmodule

// File: src/ffd_back.sv
module ffd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          queue_empty,
    input  ffd_pkg::cmd_t cmd,
    output logic          cmd_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          frame_done,
    output logic          frame_ok,
    output logic [1:0]    error_code,
    output logic [31:0]   good_count,
    output logic [31:0]   bad_count,
    output logic [7:0]    read_data
);

    logic [ffd_pkg::FRAME_BYTES-1:0] written_reg;
    ffd_pkg::count_t good_reg;
    ffd_pkg::count_t bad_reg;
    ffd_pkg::count_t good_next;
    ffd_pkg::count_t bad_next;

    logic            s1_valid_reg;
    logic            s1_done_reg;
    ffd_pkg::err_t   s1_err_reg;
    logic            s1_hit_reg;
    ffd_pkg::count_t s1_good_reg;
    ffd_pkg::count_t s1_bad_reg;

    logic            out_valid_reg;
    logic            out_done_reg;
    ffd_pkg::err_t   out_err_reg;
    ffd_pkg::count_t out_good_reg;
    ffd_pkg::count_t out_bad_reg;
    ffd_pkg::byte_t  out_data_reg;

    logic            s1_move;
    logic            s1_load;
    logic            ram_we;
    logic            ram_re;
    logic            in_range;
    logic            hit;
    ffd_pkg::byte_t  ram_q;

    assign s1_move  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign cmd_pop  = !queue_empty && (!s1_valid_reg || s1_move);
    assign in_range = (cmd.addr < ffd_pkg::addr_t'(ffd_pkg::FRAME_BYTES));
    assign hit      = in_range && written_reg[cmd.addr];
    assign ram_we   = cmd_pop && (cmd.kind == ffd_pkg::CMD_WRITE || cmd.kind == ffd_pkg::CMD_DONE);
    assign ram_re   = cmd_pop && (cmd.kind == ffd_pkg::CMD_READ) && hit;
    assign s1_load  = cmd_pop && (cmd.kind == ffd_pkg::CMD_READ || cmd.kind == ffd_pkg::CMD_DONE);

    always_comb
    begin
        good_next = good_reg;
        bad_next  = bad_reg;
        if (cmd_pop && cmd.kind == ffd_pkg::CMD_DONE)
        begin
            if (cmd.err == ffd_pkg::ERR_NONE)
            begin
                good_next = good_reg + ffd_pkg::count_t'(1);
            end
            else
            begin
                bad_next = bad_reg + ffd_pkg::count_t'(1);
            end
        end
    end

    ffd_ram #(
        .WIDTH (ffd_pkg::BYTE_W),
        .DEPTH (ffd_pkg::FRAME_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cmd.addr),
        .wdata (cmd.data),
        .re    (ram_re),
        .raddr (cmd.addr),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg   <= '0;
            good_reg      <= '0;
            bad_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ram_we)
            begin
                written_reg[cmd.addr] <= 1'b1;
            end
            good_reg <= good_next;
            bad_reg  <= bad_next;
            if (s1_load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_done_reg <= (cmd.kind == ffd_pkg::CMD_DONE);
            s1_err_reg  <= (cmd.kind == ffd_pkg::CMD_DONE) ? cmd.err : ffd_pkg::ERR_NONE;
            s1_hit_reg  <= (cmd.kind == ffd_pkg::CMD_READ) && hit;
            s1_good_reg <= good_next;
            s1_bad_reg  <= bad_next;
        end
        if (s1_move)
        begin
            out_done_reg <= s1_done_reg;
            out_err_reg  <= s1_err_reg;
            out_good_reg <= s1_good_reg;
            out_bad_reg  <= s1_bad_reg;
            out_data_reg <= s1_hit_reg ? ram_q : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_done = out_done_reg;
    assign frame_ok   = out_done_reg && (out_err_reg == ffd_pkg::ERR_NONE);
    assign error_code = out_err_reg;
    assign good_count = out_good_reg;
    assign bad_count  = out_bad_reg;
    assign read_data  = out_data_reg;

endmodule

// File: src/fixed_frame_deframer_xor_check.sv
// Fixed-length frame deframer: hunts received link bytes for a two-byte header,
// stores the 133-byte frame, and on its last byte checks the tail bytes and the
// XOR checksum, returning one report with wrapping good and bad frame counts.
// A read transaction returns one stored byte (zero past the frame or where
// never written since reset). The block takes one transaction per clock while
// the command queue has room; a result passes a stage register and an output
// register. A command queue of QUEUE_DEPTH entries sits between the header
// hunt and the frame buffer so either side can stall alone. The frame buffer
// is a single write/read memory, one access per cycle, which sets that rate.
// Buffer entries not yet written read as zero; no clearing pass follows reset.
module fixed_frame_deframer_xor_check #(
    parameter int QUEUE_DEPTH = ffd_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  read_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        frame_done,
    output logic        frame_ok,
    output logic [1:0]  error_code,
    output logic [31:0] good_count,
    output logic [31:0] bad_count,
    output logic [7:0]  read_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    ffd_pkg::cfg_t cfg_reg;
    ffd_pkg::cmd_t push_cmd;
    ffd_pkg::cmd_t pop_cmd;
    logic          queue_push;
    logic          queue_pop;
    logic          queue_full;
    logic          queue_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ffd_pkg::REG_SYNC_FIRST:  cfg_reg.sync_first  <= cfg_data;
                ffd_pkg::REG_SYNC_SECOND: cfg_reg.sync_second <= cfg_data;
                ffd_pkg::REG_TAIL_FIRST:  cfg_reg.tail_first  <= cfg_data;
                ffd_pkg::REG_TAIL_SECOND: cfg_reg.tail_second <= cfg_data;
                default:                  cfg_reg <= cfg_reg;
            endcase
        end
    end

    ffd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .rx_byte    (rx_byte),
        .read_index (read_index),
        .cfg        (cfg_reg),
        .queue_full (queue_full),
        .cmd_push   (queue_push),
        .cmd        (push_cmd)
    );

    ffd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (queue_push),
        .wdata (push_cmd),
        .full  (queue_full),
        .pop   (queue_pop),
        .empty (queue_empty),
        .rdata (pop_cmd)
    );

    ffd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .cmd         (pop_cmd),
        .cmd_pop     (queue_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .frame_done  (frame_done),
        .frame_ok    (frame_ok),
        .error_code  (error_code),
        .good_count  (good_count),
        .bad_count   (bad_count),
        .read_data   (read_data)
    );

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        !(queue_push && queue_full))
        else $error("command pushed into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(queue_pop && queue_empty))
        else $error("command popped from an empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_done) |->
            (read_data == 8'd0) && (frame_ok == (error_code == ffd_pkg::ERR_NONE)))
        else $error("frame report carries inconsistent status");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !frame_done) |-> (!frame_ok && error_code == ffd_pkg::ERR_NONE))
        else $error("read reply carries frame status");
`endif

endmodule

// File: verif/tb_fixed_frame_deframer_xor_check.sv
module tb_fixed_frame_deframer_xor_check;

    timeunit 1ns;
    timeprecision 1ps;

    import ffd_pkg::*;

    localparam int RANDOM_ITEMS = 600;
    localparam int PHASES       = 6;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [1:0] {
        ROW_ITEM  = 2'd0,
        ROW_FRAME = 2'd1,
        ROW_CFG   = 2'd2
    } row_kind_t;

    typedef enum logic [1:0] {
        FAULT_NONE = 2'd0,
        FAULT_TAIL = 2'd1,
        FAULT_SUM  = 2'd2,
        FAULT_BOTH = 2'd3
    } fault_t;

    typedef struct packed {
        row_kind_t kind;
        logic      op;
        byte_t     val;
        addr_t     idx;
        fault_t    fault;
        logic      typed;
        logic      done;
        logic      ok;
        err_t      err;
        byte_t     data;
    } plan_row_t;

    typedef struct {
        logic   done;
        logic   ok;
        err_t   err;
        count_t good;
        count_t bad;
        byte_t  data;
    } frame_report_t;

    localparam int PLAN_ROWS = 21;
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        '{ROW_ITEM,  OP_READ, 8'h00, 8'd0,   FAULT_NONE, 1'b1, 1'b0, 1'b0, ERR_NONE, 8'h00},
        '{ROW_ITEM,  OP_READ, 8'hFF, 8'd255, FAULT_NONE, 1'b1, 1'b0, 1'b0, ERR_NONE, 8'h00},
        '{ROW_CFG,   OP_RX,   8'hA5, addr_t'(REG_SYNC_FIRST),  FAULT_NONE, 1'b0, 1'b0, 1'b0,
          ERR_NONE, 8'h00},
        '{ROW_CFG,   OP_RX,   8'h5A, addr_t'(REG_SYNC_SECOND), FAULT_NONE, 1'b0, 1'b0, 1'b0,
          ERR_NONE, 8'h00},
        '{ROW_CFG,   OP_RX,   8'h0D, addr_t'(REG_TAIL_FIRST),  FAULT_NONE, 1'b0, 1'b0, 1'b0,
          ERR_NONE, 8'h00},
        '{ROW_CFG,   OP_RX,   8'h0A, addr_t'(REG_TAIL_SECOND), FAULT_NONE, 1'b0, 1'b0, 1'b0,
          ERR_NONE, 8'h00},
        '{ROW_ITEM,  OP_RX,   8'h00, 8'd255, FAULT_NONE, 1'b0, 1'b0, 1'b0, ERR_NONE, 8'h00},
        '{ROW_ITEM,  OP_RX,   8'hFF, 8'd0,   FAULT_NONE, 1'b0, 1'b0, 1'b0, ERR_NONE, 8'h00},
        '{ROW_ITEM,  OP_RX,   8'hA5, 8'd0,   FAULT_NONE, 1'b0, 1'b0, 1'b0, ERR_NONE, 8'h00},
        '{ROW_ITEM,  OP_RX,   8'h33, 8'd0,   FAULT_NONE, 1'b0, 1'b0, 1'b0, ERR_NONE, 8'h00},
        '{ROW_ITEM,  OP_RX,   8'hA5, 8'd0,   FAULT_NONE, 1'b0, 1'b0, 1'b0, ERR_NONE, 8'h00},
        '{ROW_ITEM,  OP_RX,   8'hA5, 8'd0,   FAULT_NONE, 1'b0, 1'b0, 1'b0, ERR_NONE, 8'h00},
        '{ROW_FRAME, OP_RX,   8'h00, 8'd0,   FAULT_NONE, 1'b1, 1'b1, 1'b1, ERR_NONE, 8'h00},
        '{ROW_ITEM,  OP_READ, 8'h00, 8'd0,   FAULT_NONE, 1'b1, 1'b0, 1'b0, ERR_NONE, 8'hA5},
        '{ROW_ITEM,  OP_READ, 8'h00, 8'd132, FAULT_NONE, 1'b1, 1'b0, 1'b0, ERR_NONE, 8'h0A},
        '{ROW_ITEM,  OP_READ, 8'h00, 8'd133, FAULT_NONE, 1'b1, 1'b0, 1'b0, ERR_NONE, 8'h00},
        '{ROW_FRAME, OP_RX,   8'h00, 8'd0,   FAULT_TAIL, 1'b1, 1'b1, 1'b0, ERR_TAIL, 8'h00},
        '{ROW_FRAME, OP_RX,   8'h00, 8'd0,   FAULT_SUM,  1'b1, 1'b1, 1'b0, ERR_CHECKSUM, 8'h00},
        '{ROW_FRAME, OP_RX,   8'h00, 8'd0,   FAULT_BOTH, 1'b1, 1'b1, 1'b0, ERR_TAIL, 8'h00},
        '{ROW_ITEM,  OP_READ, 8'h00, 8'd130, FAULT_NONE, 1'b0, 1'b0, 1'b0, ERR_NONE, 8'h00},
        '{ROW_ITEM,  OP_READ, 8'h00, 8'd64,  FAULT_NONE, 1'b0, 1'b0, 1'b0, ERR_NONE, 8'h00}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        op = 1'b0;
    logic [7:0]  rx_byte = 8'h00;
    logic [7:0]  read_index = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        frame_done;
    logic        frame_ok;
    logic [1:0]  error_code;
    logic [31:0] good_count;
    logic [31:0] bad_count;
    logic [7:0]  read_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [7:0]  cfg_data = 8'h00;

    byte_t  shadow_frame [FRAME_BYTES];
    int     shadow_fill;
    byte_t  shadow_xor;
    count_t shadow_good;
    count_t shadow_bad;
    cfg_t   shadow_cfg;

    frame_report_t expected_reports [$];
    frame_report_t oldest_report;
    frame_report_t blank_report;

    int unsigned error_count = 0;
    int unsigned items_done = 0;
    int unsigned idle_cycles = 0;
    int unsigned stall_left = 0;
    bit          quiet = 1'b0;

    fixed_frame_deframer_xor_check u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .rx_byte    (rx_byte),
        .read_index (read_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_done (frame_done),
        .frame_ok   (frame_ok),
        .error_code (error_code),
        .good_count (good_count),
        .bad_count  (bad_count),
        .read_data  (read_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic addr_t pick_index();
        if ($urandom_range(0, 99) < 85)
            return addr_t'($urandom_range(0, FRAME_BYTES - 1));
        return addr_t'($urandom_range(FRAME_BYTES, 255));
    endfunction

    function automatic fault_t pick_fault();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return FAULT_NONE;
        if (r < 7)
            return FAULT_TAIL;
        if (r < 9)
            return FAULT_SUM;
        return FAULT_BOTH;
    endfunction

    function automatic byte_t pick_link_byte();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return shadow_cfg.sync_first;
        if (r < 5)
            return shadow_cfg.sync_second;
        return byte_t'($urandom);
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
        error_count++;
    endtask

    task automatic start_shadow_frame();
        shadow_frame[0] = shadow_cfg.sync_first;
        shadow_fill = 1;
        shadow_xor = shadow_cfg.sync_first;
    endtask

    task automatic deframe_predict(input logic opv, input byte_t b, input addr_t idx,
                                   output bit has_report, output frame_report_t rep);
        err_t err;
        has_report = 1'b0;
        rep = blank_report;
        rep.good = shadow_good;
        rep.bad = shadow_bad;
        if (opv == OP_READ)
        begin
            rep.data = (idx < FRAME_BYTES) ? shadow_frame[idx] : 8'h00;
            has_report = 1'b1;
            return;
        end
        if (shadow_fill == 0)
        begin
            if (b == shadow_cfg.sync_first)
                start_shadow_frame();
            return;
        end
        if (shadow_fill == 1)
        begin
            if (b == shadow_cfg.sync_second)
            begin
                shadow_frame[1] = b;
                shadow_xor ^= b;
                shadow_fill = 2;
            end
            else if (b == shadow_cfg.sync_first)
                start_shadow_frame();
            else
                shadow_fill = 0;
            return;
        end
        shadow_frame[shadow_fill] = b;
        if (shadow_fill < CHECK_POS)
            shadow_xor ^= b;
        shadow_fill++;
        if (shadow_fill != FRAME_BYTES)
            return;
        if (shadow_frame[TAIL_POS] != shadow_cfg.tail_first ||
            shadow_frame[TAIL_POS + 1] != shadow_cfg.tail_second)
            err = ERR_TAIL;
        else if (shadow_xor != shadow_frame[CHECK_POS])
            err = ERR_CHECKSUM;
        else
            err = ERR_NONE;
        if (err == ERR_NONE)
            shadow_good++;
        else
            shadow_bad++;
        shadow_fill = 0;
        shadow_xor = 8'h00;
        rep.done = 1'b1;
        rep.ok = (err == ERR_NONE);
        rep.err = err;
        rep.good = shadow_good;
        rep.bad = shadow_bad;
        has_report = 1'b1;
    endtask

    task automatic send_checked(input logic opv, input byte_t b, input addr_t idx,
                                input bit typed, input frame_report_t want);
        int unsigned gap;
        bit has_report;
        frame_report_t rep;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= opv;
        rx_byte <= b;
        read_index <= idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (!(opv == OP_RX && shadow_fill == 0 && b != shadow_cfg.sync_first))
            items_done++;
        deframe_predict(opv, b, idx, has_report, rep);
        if (has_report)
        begin
            if (typed)
            begin
                rep.done = want.done;
                rep.ok = want.ok;
                rep.err = want.err;
                rep.data = want.data;
            end
            expected_reports.push_back(rep);
        end
    endtask

    task automatic send_item(input logic opv, input byte_t b, input addr_t idx);
        send_checked(opv, b, idx, 1'b0, blank_report);
    endtask

    task automatic drain_all();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_reports.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input byte_t v);
        drain_all();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SYNC_FIRST:  shadow_cfg.sync_first = v;
            REG_SYNC_SECOND: shadow_cfg.sync_second = v;
            REG_TAIL_FIRST:  shadow_cfg.tail_first = v;
            REG_TAIL_SECOND: shadow_cfg.tail_second = v;
            default: ;
        endcase
    endtask

    task automatic send_frame(input fault_t fault, input int unsigned read_pct,
                              input bit typed, input frame_report_t want);
        byte_t body [FRAME_BYTES];
        byte_t sum;
        int unsigned which;
        while (shadow_fill >= 2)
            send_item(OP_RX, byte_t'($urandom), addr_t'($urandom));
        if (shadow_fill == 0)
            send_item(OP_RX, shadow_cfg.sync_first, addr_t'($urandom));
        body[0] = shadow_cfg.sync_first;
        body[1] = shadow_cfg.sync_second;
        sum = body[0] ^ body[1];
        for (int k = 2; k < CHECK_POS; k++)
        begin
            body[k] = byte_t'($urandom);
            sum ^= body[k];
        end
        body[CHECK_POS] = sum;
        body[TAIL_POS] = shadow_cfg.tail_first;
        body[TAIL_POS + 1] = shadow_cfg.tail_second;
        if (fault == FAULT_SUM || fault == FAULT_BOTH)
            body[CHECK_POS] ^= byte_t'($urandom_range(1, 255));
        if (fault == FAULT_TAIL || fault == FAULT_BOTH)
        begin
            which = $urandom_range(0, 2);
            if (which != 1)
                body[TAIL_POS] ^= byte_t'($urandom_range(1, 255));
            if (which != 0)
                body[TAIL_POS + 1] ^= byte_t'($urandom_range(1, 255));
        end
        for (int k = 1; k < FRAME_BYTES; k++)
        begin
            if ($urandom_range(0, 99) < read_pct)
                send_item(OP_READ, byte_t'($urandom), pick_index());
            if (k == FRAME_BYTES - 1)
                send_checked(OP_RX, body[k], addr_t'($urandom), typed, want);
            else
                send_item(OP_RX, body[k], addr_t'($urandom));
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_reports.size() == 0)
                report_mismatch("unexpected result", 32'd0, 32'd0);
            else
            begin
                oldest_report = expected_reports.pop_front();
                if (frame_done !== oldest_report.done)
                    report_mismatch("frame_done", 32'(frame_done), 32'(oldest_report.done));
                if (frame_ok !== oldest_report.ok)
                    report_mismatch("frame_ok", 32'(frame_ok), 32'(oldest_report.ok));
                if (error_code !== oldest_report.err)
                    report_mismatch("error_code", 32'(error_code), 32'(oldest_report.err));
                if (good_count !== oldest_report.good)
                    report_mismatch("good_count", good_count, oldest_report.good);
                if (bad_count !== oldest_report.bad)
                    report_mismatch("bad_count", bad_count, oldest_report.bad);
                if (read_data !== oldest_report.data)
                    report_mismatch("read_data", 32'(read_data), 32'(oldest_report.data));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        plan_row_t row;
        frame_report_t want;
        cfg_t phase_cfg;
        int unsigned target;
        int unsigned r;

        blank_report.done = 1'b0;
        blank_report.ok = 1'b0;
        blank_report.err = ERR_NONE;
        blank_report.good = '0;
        blank_report.bad = '0;
        blank_report.data = '0;
        foreach (shadow_frame[k])
            shadow_frame[k] = 8'h00;
        shadow_fill = 0;
        shadow_xor = 8'h00;
        shadow_good = '0;
        shadow_bad = '0;
        shadow_cfg = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            row = PLAN[i];
            want = blank_report;
            want.done = row.done;
            want.ok = row.ok;
            want.err = row.err;
            want.data = row.data;
            case (row.kind)
                ROW_CFG:   write_reg(row.idx[CFG_IDX_W-1:0], row.val);
                ROW_FRAME: send_frame(row.fault, 0, row.typed, want);
                default:   send_checked(row.op, row.val, row.idx, row.typed, want);
            endcase
        end

        items_done = 0;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: phase_cfg = '{8'h00, 8'h00, 8'h00, 8'h00};
                1: phase_cfg = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
                2: phase_cfg = '{8'h00, 8'hFF, 8'hFF, 8'h00};
                default:
                begin
                    phase_cfg.sync_first = byte_t'($urandom);
                    phase_cfg.sync_second = ($urandom_range(0, 2) == 0) ?
                                            phase_cfg.sync_first : byte_t'($urandom);
                    phase_cfg.tail_first = byte_t'($urandom);
                    phase_cfg.tail_second = byte_t'($urandom);
                end
            endcase
            write_reg(REG_SYNC_FIRST, phase_cfg.sync_first);
            write_reg(REG_SYNC_SECOND, phase_cfg.sync_second);
            write_reg(REG_TAIL_FIRST, phase_cfg.tail_first);
            write_reg(REG_TAIL_SECOND, phase_cfg.tail_second);

            target = (RANDOM_ITEMS / PHASES) * (p + 1);
            while (items_done < target)
            begin
                quiet = ($urandom_range(0, 3) == 0);
                r = $urandom_range(0, 99);
                if (r < 55)
                    send_frame(pick_fault(), 4, 1'b0, blank_report);
                else if (r < 70)
                    repeat ($urandom_range(1, 4))
                        send_item(OP_READ, byte_t'($urandom), pick_index());
                else if (r < 85)
                    repeat ($urandom_range(1, 6))
                        send_item(OP_RX, pick_link_byte(), addr_t'($urandom));
                else if (r < 97)
                begin
                    // truncated frame: the next frame fills it out with noise
                    if (shadow_fill == 0)
                        send_item(OP_RX, shadow_cfg.sync_first, addr_t'($urandom));
                    send_item(OP_RX, pick_link_byte(), addr_t'($urandom));
                    repeat ($urandom_range(0, 60))
                        send_item(OP_RX, byte_t'($urandom), addr_t'($urandom));
                end
                else
                    drain_all();
            end
        end

        quiet = 1'b0;
        drain_all();
        while (expected_reports.size() != 0)
        begin
            oldest_report = expected_reports.pop_front();
            report_mismatch("missing result", 32'd0, 32'(oldest_report.data));
        end
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: fixed_frame_deframer_xor_check.f
src/ffd_pkg.sv
src/ffd_ram.sv
src/ffd_fifo.sv
src/ffd_front.sv
src/ffd_back.sv
src/fixed_frame_deframer_xor_check.sv
verif/tb_fixed_frame_deframer_xor_check.sv
